FILE: rtl/core/ising_metropolis_spin_update_assert.svh
// assertion macros shared by the spin update checker
`ifndef ISING_METROPOLIS_SPIN_UPDATE_ASSERT_SVH
`define ISING_METROPOLIS_SPIN_UPDATE_ASSERT_SVH

// same-cycle implication, disabled while reset is held
`define ISING_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is held
`define ISING_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle implication that also holds across reset
`define ISING_ASSERT_NXT_NR(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/ising_pkg.sv
// shared constants for the ising spin update block
`default_nettype none

package ising_pkg;

    // default parameter values
    localparam int LATTICE_SIDE_DEF = 64;
    localparam int RAND_BITS_DEF    = 16;

    // field widths
    localparam int ROW_W  = 6;
    localparam int COL_W  = 6;
    localparam int RND_W  = 16;
    localparam int THR_W  = 16;
    localparam int SIGN_W = 2;
    localparam int MAG_W  = 14;

    // stream bus widths
    localparam int S_DATA_W = 32;
    localparam int S_USER_W = 1;
    localparam int M_DATA_W = 24;

    // input beat layout
    localparam int IN_ROW_LSB  = 0;
    localparam int IN_COL_LSB  = IN_ROW_LSB + ROW_W;
    localparam int IN_RND_LSB  = IN_COL_LSB + COL_W;
    localparam int IN_LSPN_LSB = IN_RND_LSB + RND_W;

    // output beat layout
    localparam int OUT_FLIP_LSB = 0;
    localparam int OUT_SPIN_LSB = 1;
    localparam int OUT_SIGN_LSB = 2;
    localparam int OUT_MAG_LSB  = OUT_SIGN_LSB + SIGN_W;
    localparam int OUT_USED_W   = OUT_MAG_LSB + MAG_W;

    // request kinds
    localparam logic REQ_UPDATE = 1'b0;
    localparam logic REQ_LOAD   = 1'b1;

    // energy sign codes
    localparam logic signed [SIGN_W-1:0] SIGN_NEG  = -2'sd1;
    localparam logic signed [SIGN_W-1:0] SIGN_ZERO = 2'sd0;
    localparam logic signed [SIGN_W-1:0] SIGN_POS  = 2'sd1;

    // register reset value
    localparam logic [THR_W-1:0] ACCEPT_THR_RST = 16'd32768;

endpackage

`default_nettype wire

FILE: rtl/core/ising_metropolis_spin_update.sv
// metropolis single-spin update on a periodic square ising lattice
//
// Takes one update or load beat per clock while not clearing and results are
// taken, and returns one result beat per input beat. The three lattice rows are
// read at acceptance; decision and write-back are done as the item moves into the
// output register; it waits while a result is stalled. The lattice is kept as
// rows of LATTICE_SIDE bits in three identical row memories, one read port each
// (row above, own row, row below), so an item reads all five sites in one access;
// the last write-back is forwarded to the next item. After reset a clearing pass
// sets every row to all spins up, one row per cycle; o_s_axis_tready is low
// during it. Configuration writes are taken at any time. The output register lets
// the block take a new beat while a result waits to be taken.
`default_nettype none

module ising_metropolis_spin_update #(
    parameter int LATTICE_SIDE = ising_pkg::LATTICE_SIDE_DEF,
    parameter int RAND_BITS    = ising_pkg::RAND_BITS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // config register: accept_threshold
    input  wire logic                            i_cfg_we,
    input  wire logic [ising_pkg::THR_W-1:0]     i_cfg_wdata,
    // input stream
    input  wire logic                            i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    // tdata: row[5:0], column[11:6], rand_fraction[27:12], load_spin[28], zero fill
    input  wire logic [ising_pkg::S_DATA_W-1:0]  i_s_axis_tdata,
    // tuser: req_type[0]
    input  wire logic [ising_pkg::S_USER_W-1:0]  i_s_axis_tuser,
    // output stream
    output logic                                 o_m_axis_tvalid,
    input  wire logic                            i_m_axis_tready,
    // tdata: flipped[0], spin_now[1], energy_sign[3:2], magnetisation[17:4], zero fill
    output logic [ising_pkg::M_DATA_W-1:0]       o_m_axis_tdata
);

    localparam int IDX_W    = (LATTICE_SIDE > 1) ? $clog2(LATTICE_SIDE) : 1;
    localparam int SITES    = LATTICE_SIDE * LATTICE_SIDE;
    localparam int SUM_W    = $clog2(SITES + 1) + 1;
    localparam int IN_SPAN  = 2 ** ising_pkg::ROW_W;
    localparam int RB_EXT   = (RAND_BITS > ising_pkg::RND_W) ? RAND_BITS : ising_pkg::RND_W;
    localparam int CMP_W    = ising_pkg::THR_W + RB_EXT;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(LATTICE_SIDE - 1);
    localparam logic [ising_pkg::RND_W-1:0] RND_MASK =
        (RAND_BITS >= ising_pkg::RND_W) ? '1 : ising_pkg::RND_W'((64'd1 << RAND_BITS) - 1);
    localparam logic [CMP_W-1:0] HALF_VAL = CMP_W'(1) << (RAND_BITS - 1);
    localparam logic signed [SUM_W-1:0] SUM_RST = SUM_W'(SITES);
    localparam logic signed [SUM_W-1:0] SUM_TWO = SUM_W'(2);

    typedef logic [LATTICE_SIDE-1:0] t_row;

    // configuration register
    logic [ising_pkg::THR_W-1:0] r_accept_thr;

    // clearing pass
    logic             r_clr_busy;
    logic [IDX_W-1:0] r_clr_cnt;

    // row memories
    t_row r_lat_up  [LATTICE_SIDE];
    t_row r_lat_mid [LATTICE_SIDE];
    t_row r_lat_dn  [LATTICE_SIDE];
    t_row r_rd_up, r_rd_mid, r_rd_dn;

    // item stage after the read
    logic                        r_s1_valid;
    logic                        r_s1_load;
    logic                        r_s1_lspin;
    logic [IDX_W-1:0]            r_s1_row_up, r_s1_row_mid, r_s1_row_dn;
    logic [IDX_W-1:0]            r_s1_col;
    logic [ising_pkg::RND_W-1:0] r_s1_rnd;

    // last write-back, forwarded to the item read at the same edge
    logic             r_wb_valid;
    logic [IDX_W-1:0] r_wb_row;
    t_row             r_wb_data;

    // running magnetisation
    logic signed [SUM_W-1:0] r_sum;
    logic signed [SUM_W-1:0] n_sum;

    // output register
    logic                               r_out_valid;
    logic                               r_out_flip;
    logic                               r_out_spin;
    logic signed [ising_pkg::SIGN_W-1:0] r_out_sign;
    logic [ising_pkg::MAG_W-1:0]        r_out_mag;

    // handshake
    logic w_in_acc;
    logic w_s1_adv;

    assign w_s1_adv        = r_s1_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_clr_busy && (!r_s1_valid || w_s1_adv);
    assign w_in_acc        = i_s_axis_tvalid && o_s_axis_tready;

    // index reduction table for the narrow row and column fields
    logic [IDX_W-1:0] w_mod_tab [IN_SPAN];
    for (genvar g = 0; g < IN_SPAN; g++) begin : g_mod
        assign w_mod_tab[g] = IDX_W'(g % LATTICE_SIDE);
    end

    // input decode and neighbor rows
    logic [IDX_W-1:0] w_in_row, w_in_col, w_in_up, w_in_dn;
    assign w_in_row = w_mod_tab[i_s_axis_tdata[ising_pkg::IN_ROW_LSB +: ising_pkg::ROW_W]];
    assign w_in_col = w_mod_tab[i_s_axis_tdata[ising_pkg::IN_COL_LSB +: ising_pkg::COL_W]];
    assign w_in_up  = (w_in_row == '0) ? IDX_LAST : w_in_row - 1'b1;
    assign w_in_dn  = (w_in_row == IDX_LAST) ? '0 : w_in_row + 1'b1;

    // write port shared by clearing pass and write-back
    logic             w_mem_we;
    logic [IDX_W-1:0] w_mem_wa;
    t_row             w_mem_wd;
    t_row             w_row_new;

    assign w_mem_we = r_clr_busy || w_s1_adv;
    assign w_mem_wa = r_clr_busy ? r_clr_cnt : r_s1_row_mid;
    assign w_mem_wd = r_clr_busy ? '1 : w_row_new;

    // row memory copies, same writes, one read address each
    always_ff @(posedge i_clk) begin
        if (w_mem_we) r_lat_up[w_mem_wa] <= w_mem_wd;
        if (w_in_acc) r_rd_up <= r_lat_up[w_in_up];
    end

    always_ff @(posedge i_clk) begin
        if (w_mem_we) r_lat_mid[w_mem_wa] <= w_mem_wd;
        if (w_in_acc) r_rd_mid <= r_lat_mid[w_in_row];
    end

    always_ff @(posedge i_clk) begin
        if (w_mem_we) r_lat_dn[w_mem_wa] <= w_mem_wd;
        if (w_in_acc) r_rd_dn <= r_lat_dn[w_in_dn];
    end

    // forwarded rows
    t_row w_row_up, w_row_mid, w_row_dn;
    assign w_row_up  = (r_wb_valid && r_wb_row == r_s1_row_up)  ? r_wb_data : r_rd_up;
    assign w_row_mid = (r_wb_valid && r_wb_row == r_s1_row_mid) ? r_wb_data : r_rd_mid;
    assign w_row_dn  = (r_wb_valid && r_wb_row == r_s1_row_dn)  ? r_wb_data : r_rd_dn;

    // neighbor columns
    logic [IDX_W-1:0] w_col_l, w_col_r;
    assign w_col_l = (r_s1_col == '0) ? IDX_LAST : r_s1_col - 1'b1;
    assign w_col_r = (r_s1_col == IDX_LAST) ? '0 : r_s1_col + 1'b1;

    // acceptance compares
    logic [CMP_W-1:0] w_thr_sh, w_rnd_sh;
    logic             w_half_ok, w_thr_ok;
    assign w_thr_sh  = CMP_W'(r_accept_thr) << RAND_BITS;
    assign w_rnd_sh  = CMP_W'(r_s1_rnd) << ising_pkg::THR_W;
    assign w_half_ok = HALF_VAL > CMP_W'(r_s1_rnd);
    assign w_thr_ok  = w_thr_sh > w_rnd_sh;

    // energy sign, flip decision and new row
    logic                                w_spin_old, w_spin_new, w_flip, w_accept;
    logic [2:0]                          w_ups;
    logic signed [ising_pkg::SIGN_W-1:0] w_nsign, w_sign;

    always_comb begin
        w_spin_old = w_row_mid[r_s1_col];
        w_ups = {2'b00, w_row_up[r_s1_col]} + {2'b00, w_row_dn[r_s1_col]}
              + {2'b00, w_row_mid[w_col_l]} + {2'b00, w_row_mid[w_col_r]};
        if (w_ups > 3'd2) begin
            w_nsign = ising_pkg::SIGN_POS;
        end else if (w_ups < 3'd2) begin
            w_nsign = ising_pkg::SIGN_NEG;
        end else begin
            w_nsign = ising_pkg::SIGN_ZERO;
        end
        if (r_s1_load == ising_pkg::REQ_LOAD) begin
            w_sign = ising_pkg::SIGN_ZERO;
        end else if (w_spin_old) begin
            w_sign = w_nsign;
        end else begin
            w_sign = -w_nsign;
        end
        case (w_sign)
            ising_pkg::SIGN_NEG:  w_accept = 1'b1;
            ising_pkg::SIGN_ZERO: w_accept = w_half_ok;
            ising_pkg::SIGN_POS:  w_accept = w_thr_ok;
            default:              w_accept = 1'b0;
        endcase
        w_flip     = (r_s1_load == ising_pkg::REQ_UPDATE) && w_accept;
        w_spin_new = (r_s1_load == ising_pkg::REQ_LOAD) ? r_s1_lspin : (w_spin_old ^ w_flip);
        w_row_new  = w_row_mid;
        w_row_new[r_s1_col] = w_spin_new;
        if (w_spin_new == w_spin_old) begin
            n_sum = r_sum;
        end else if (w_spin_new) begin
            n_sum = r_sum + SUM_TWO;
        end else begin
            n_sum = r_sum - SUM_TWO;
        end
    end

    // control state, config register, magnetisation, output flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accept_thr <= ising_pkg::ACCEPT_THR_RST;
            r_clr_busy   <= 1'b1;
            r_clr_cnt    <= '0;
            r_s1_valid   <= 1'b0;
            r_wb_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_sum        <= SUM_RST;
        end else begin
            if (i_cfg_we) r_accept_thr <= i_cfg_wdata;
            if (r_clr_busy) begin
                r_clr_cnt <= r_clr_cnt + 1'b1;
                if (r_clr_cnt == IDX_LAST) r_clr_busy <= 1'b0;
            end
            if (w_in_acc) begin
                r_s1_valid <= 1'b1;
            end else if (w_s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (w_s1_adv) begin
                r_out_valid <= 1'b1;
                r_wb_valid  <= 1'b1;
                r_sum       <= n_sum;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_s1_load    <= i_s_axis_tuser[0];
            r_s1_lspin   <= i_s_axis_tdata[ising_pkg::IN_LSPN_LSB];
            r_s1_row_up  <= w_in_up;
            r_s1_row_mid <= w_in_row;
            r_s1_row_dn  <= w_in_dn;
            r_s1_col     <= w_in_col;
            r_s1_rnd     <= i_s_axis_tdata[ising_pkg::IN_RND_LSB +: ising_pkg::RND_W] & RND_MASK;
        end
        if (w_s1_adv) begin
            r_wb_row   <= r_s1_row_mid;
            r_wb_data  <= w_row_new;
            r_out_flip <= w_flip;
            r_out_spin <= w_spin_new;
            r_out_sign <= w_sign;
            r_out_mag  <= ising_pkg::MAG_W'(n_sum);
        end
    end

    // result beat
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(ising_pkg::M_DATA_W - ising_pkg::OUT_USED_W){1'b0}},
                              r_out_mag, r_out_sign, r_out_spin, r_out_flip};

endmodule

`default_nettype wire

FILE: rtl/core/ising_chk.sv
// port-level checker for the ising spin update block, with its bind
`default_nettype none

`include "ising_metropolis_spin_update_assert.svh"

module ising_chk (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            i_s_axis_tvalid,
    input wire logic                            o_s_axis_tready,
    input wire logic                            o_m_axis_tvalid,
    input wire logic                            i_m_axis_tready,
    input wire logic [ising_pkg::M_DATA_W-1:0]  o_m_axis_tdata
);

    // beats accepted but not yet delivered
    logic [2:0] r_pending;
    logic       w_in_beat, w_out_beat;

    assign w_in_beat  = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_beat = o_m_axis_tvalid && i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else if (w_in_beat && !w_out_beat) begin
            r_pending <= r_pending + 1'b1;
        end else if (!w_in_beat && w_out_beat) begin
            r_pending <= r_pending - 1'b1;
        end
    end

    // a stalled result beat holds
    `ISING_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata), "result beat dropped or changed while stalled")

    // no result beat without an accepted item, and at most two in flight
    `ISING_ASSERT_IMP(a_pending, i_clk, i_rst_n, o_m_axis_tvalid, r_pending != 3'd0 && r_pending <= 3'd2, "result beat count does not match accepted beats")

    // a negative energy sign always flips
    `ISING_ASSERT_IMP(a_neg_flips, i_clk, i_rst_n, o_m_axis_tvalid && o_m_axis_tdata[ising_pkg::OUT_SIGN_LSB +: ising_pkg::SIGN_W] == ising_pkg::SIGN_NEG, o_m_axis_tdata[ising_pkg::OUT_FLIP_LSB], "negative sign without flip")

    // reset empties the output and starts the clearing pass
    `ISING_ASSERT_NXT_NR(a_rst_out, i_clk, !i_rst_n, !o_m_axis_tvalid, "result valid right after reset")
    `ISING_ASSERT_NXT_NR(a_rst_rdy, i_clk, !i_rst_n, !o_s_axis_tready, "input ready during lattice clearing")

endmodule

bind ising_metropolis_spin_update ising_chk u_ising_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

`default_nettype wire

FILE: test/testbench.sv
// testbench for the ising spin update block, results predicted and checked beat by beat
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SIDE           = ising_pkg::LATTICE_SIDE_DEF;
    localparam int LONG_HOLD      = 250;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam logic [ising_pkg::RND_W-1:0] HALF_FRACTION = 16'h8000;

    // one request beat and one result beat, as fields
    typedef struct packed {
        logic                        kind;
        logic [ising_pkg::ROW_W-1:0] row;
        logic [ising_pkg::COL_W-1:0] column;
        logic [ising_pkg::RND_W-1:0] rnd;
        logic                        load_spin;
    } t_spin_req;

    typedef struct packed {
        logic                                flipped;
        logic                                spin_now;
        logic signed [ising_pkg::SIGN_W-1:0] energy_sign;
        logic signed [ising_pkg::MAG_W-1:0]  magnetisation;
    } t_site_result;

    // dut connections, all inputs known from time zero
    logic                           clk       = 1'b0;
    logic                           rst_n     = 1'b0;
    logic                           cfg_we    = 1'b0;
    logic [ising_pkg::THR_W-1:0]    cfg_wdata = '0;
    logic                           s_valid   = 1'b0;
    logic [ising_pkg::S_DATA_W-1:0] s_data    = '0;
    logic [ising_pkg::S_USER_W-1:0] s_user    = '0;
    logic                           m_ready   = 1'b0;
    wire                            s_ready;
    wire                            m_valid;
    wire  [ising_pkg::M_DATA_W-1:0] m_data;

    // predicted lattice, magnetisation and threshold
    bit                                 spin_grid [SIDE][SIDE];
    logic signed [ising_pkg::MAG_W-1:0] mag_sum;
    logic [ising_pkg::THR_W-1:0]        accept_thr;

    t_site_result                spin_results_due[$];
    int                          fail_count  = 0;
    int                          quiet_cycles = 0;
    int                          rx_stall_left = 0;
    bit                          long_hold_req = 1'b0;
    bit                          tx_steady = 1'b0;
    bit                          rx_steady = 1'b0;
    logic [ising_pkg::ROW_W-1:0] hot_row = '0;
    logic [ising_pkg::COL_W-1:0] hot_col = '0;

    ising_metropolis_spin_update i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_wdata     (cfg_wdata),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data)
    );

    always #5 clk = ~clk;

    // mostly no gap, some short ones, a few long ones
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 65) return 0;
        if (roll < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic void reset_lattice();
        foreach (spin_grid[r, c]) spin_grid[r][c] = 1'b1;
        mag_sum    = ising_pkg::MAG_W'(SIDE * SIDE);
        accept_thr = ising_pkg::ACCEPT_THR_RST;
    endfunction

    // store one spin and keep the magnetisation current
    function automatic void write_site(logic [ising_pkg::ROW_W-1:0] r,
                                       logic [ising_pkg::COL_W-1:0] c, logic v);
        if (spin_grid[r][c] != v) mag_sum = v ? mag_sum + 14'sd2 : mag_sum - 14'sd2;
        spin_grid[r][c] = v;
    endfunction

    // metropolis decision or load, as the block should do it
    function automatic t_site_result predict_spin_update(t_spin_req req);
        t_site_result                        res;
        logic [ising_pkg::ROW_W-1:0]         up_row, dn_row;
        logic [ising_pkg::COL_W-1:0]         lf_col, rt_col;
        int                                  ups;
        logic signed [ising_pkg::SIGN_W-1:0] nbr_sign;
        logic                                cur;
        logic                                take;
        res = '0;
        cur = spin_grid[req.row][req.column];
        if (req.kind == ising_pkg::REQ_LOAD) begin
            write_site(req.row, req.column, req.load_spin);
            res.energy_sign = ising_pkg::SIGN_ZERO;
        end else begin
            // periodic borders wrap through the index width
            up_row = req.row - 1'b1;
            dn_row = req.row + 1'b1;
            lf_col = req.column - 1'b1;
            rt_col = req.column + 1'b1;
            ups = int'(spin_grid[up_row][req.column]) + int'(spin_grid[dn_row][req.column])
                + int'(spin_grid[req.row][lf_col]) + int'(spin_grid[req.row][rt_col]);
            if (ups > 2) begin
                nbr_sign = ising_pkg::SIGN_POS;
            end else if (ups < 2) begin
                nbr_sign = ising_pkg::SIGN_NEG;
            end else begin
                nbr_sign = ising_pkg::SIGN_ZERO;
            end
            res.energy_sign = cur ? nbr_sign : -nbr_sign;
            if (res.energy_sign == ising_pkg::SIGN_NEG) begin
                take = 1'b1;
            end else if (res.energy_sign == ising_pkg::SIGN_ZERO) begin
                take = req.rnd < HALF_FRACTION;
            end else begin
                take = req.rnd < accept_thr;
            end
            if (take) write_site(req.row, req.column, ~cur);
            res.flipped = take;
        end
        res.spin_now      = spin_grid[req.row][req.column];
        res.magnetisation = mag_sum;
        return res;
    endfunction

    // random request, sites often clustered so neighbours interact
    function automatic t_spin_req random_request();
        t_spin_req                   req;
        logic [ising_pkg::RND_W-1:0] nudge;
        req.kind      = ($urandom_range(0, 4) == 0) ? ising_pkg::REQ_LOAD : ising_pkg::REQ_UPDATE;
        req.row       = ising_pkg::ROW_W'($urandom());
        req.column    = ising_pkg::COL_W'($urandom());
        req.load_spin = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 1)) begin
            req.row    = hot_row + req.row[1:0];
            req.column = hot_col + req.column[1:0];
        end
        nudge = ising_pkg::RND_W'($urandom_range(0, 3));
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: req.rnd = ising_pkg::RND_W'($urandom());
            5, 6:          req.rnd = accept_thr + nudge - 16'd2;
            7:             req.rnd = HALF_FRACTION + nudge - 16'd2;
            default: begin
                case (nudge)
                    16'd0:   req.rnd = '0;
                    16'd1:   req.rnd = '1;
                    16'd2:   req.rnd = HALF_FRACTION - 16'd1;
                    default: req.rnd = HALF_FRACTION;
                endcase
            end
        endcase
        return req;
    endfunction

    // offer one request beat, predict its result once accepted
    task automatic send_request(input t_spin_req req);
        logic [ising_pkg::S_DATA_W-1:0] beat;
        int                             gap;
        t_site_result                   res;
        beat = '0;
        beat[ising_pkg::IN_ROW_LSB  +: ising_pkg::ROW_W] = req.row;
        beat[ising_pkg::IN_COL_LSB  +: ising_pkg::COL_W] = req.column;
        beat[ising_pkg::IN_RND_LSB  +: ising_pkg::RND_W] = req.rnd;
        beat[ising_pkg::IN_LSPN_LSB]                     = req.load_spin;
        gap = tx_steady ? 0 : pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_valid <= 1'b1;
        s_data  <= beat;
        s_user  <= req.kind;
        do @(posedge clk); while (!s_ready);
        res = predict_spin_update(req);
        spin_results_due = {spin_results_due, res};
    endtask

    task automatic send_update(input logic [ising_pkg::ROW_W-1:0] r,
                               input logic [ising_pkg::COL_W-1:0] c,
                               input logic [ising_pkg::RND_W-1:0] rnd);
        t_spin_req req;
        req = '{kind: ising_pkg::REQ_UPDATE, row: r, column: c, rnd: rnd, load_spin: 1'b0};
        send_request(req);
    endtask

    task automatic send_load(input logic [ising_pkg::ROW_W-1:0] r,
                             input logic [ising_pkg::COL_W-1:0] c, input logic v);
        t_spin_req req;
        req = '{kind: ising_pkg::REQ_LOAD, row: r, column: c,
                rnd: ising_pkg::RND_W'($urandom()), load_spin: v};
        send_request(req);
    endtask

    // stop offering and wait for every predicted result
    task automatic drain_results();
        s_valid <= 1'b0;
        while (spin_results_due.size() != 0) @(posedge clk);
        @(posedge clk);
    endtask

    task automatic write_threshold(input logic [ising_pkg::THR_W-1:0] value);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we     <= 1'b0;
        accept_thr = value;
    endtask

    task automatic run_random(input int count);
        for (int i = 0; i < count; i++) begin
            // new idle pattern and cluster spot every few dozen beats
            if (i % 40 == 0) begin
                tx_steady = ($urandom_range(0, 3) == 0);
                rx_steady = ($urandom_range(0, 3) == 0);
                hot_row   = ising_pkg::ROW_W'($urandom());
                hot_col   = ising_pkg::COL_W'($urandom());
            end
            send_request(random_request());
        end
    endtask

    // corners, all three energy signs and loads, reset threshold
    task automatic test_directed_sites();
        send_update(0, 0, 16'hFFFF);     // positive sign, no flip
        send_update(63, 63, 16'h0000);   // positive sign, flips down
        send_update(63, 63, 16'hFFFF);   // down among up neighbours, always flips
        send_update(0, 63, 16'h7FFF);    // just below threshold, flips
        send_update(63, 0, 16'h8000);    // exactly threshold, no flip
        send_load(0, 63, 1'b1);
        send_load(32, 32, 1'b0);
        send_load(32, 32, 1'b0);         // load of the same value
        send_load(4, 5, 1'b0);
        send_load(6, 5, 1'b0);
        send_update(5, 5, 16'h7FFF);     // zero sign, below one half
        send_update(5, 5, 16'h8000);     // zero sign, exactly one half
        send_update(5, 5, 16'h0000);     // zero sign from a down spin
        send_load(39, 40, 1'b0);
        send_load(40, 39, 1'b0);
        send_load(40, 41, 1'b0);
        send_update(40, 40, 16'hFFFF);   // up spin among mostly down, always flips
        send_update(40, 40, 16'h0000);   // down spin among mostly down, positive sign
        send_load(32, 32, 1'b1);
        send_update(31, 31, 16'h8001);
    endtask

    // threshold extremes and two random settings
    task automatic test_threshold_sweep();
        logic [ising_pkg::THR_W-1:0] settings[6];
        settings = '{16'h0000, 16'hFFFF, 16'h0001, 16'hFFFE, 16'h0000, 16'h0000};
        settings[4] = ising_pkg::THR_W'($urandom());
        settings[5] = ising_pkg::THR_W'($urandom());
        foreach (settings[k]) begin
            write_threshold(settings[k]);
            run_random(190);
        end
    endtask

    // sink holds off for a long stretch while beats keep coming
    task automatic test_input_backpressure();
        tx_steady     = 1'b1;
        long_hold_req = 1'b1;
        for (int i = 0; i < 60; i++) send_request(random_request());
        tx_steady = 1'b0;
    endtask

    task automatic test_random_mix();
        write_threshold(ising_pkg::ACCEPT_THR_RST);
        run_random(240);
        write_threshold(ising_pkg::THR_W'($urandom()));
        run_random(240);
    endtask

    // sink ready with random gaps, plus a long hold on request
    initial begin : sink_ready
        forever begin
            @(posedge clk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                rx_stall_left = LONG_HOLD;
            end
            if (rx_stall_left > 0) begin
                m_ready <= 1'b0;
                rx_stall_left--;
            end else begin
                m_ready <= 1'b1;
                if (!rx_steady) rx_stall_left = pick_gap();
            end
        end
    end

    function automatic void compare_field(string name, int want, int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
            fail_count++;
        end
    endfunction

    // compare each result beat with the oldest prediction
    always @(posedge clk) begin : result_check
        t_site_result want;
        if (rst_n && m_valid && m_ready) begin
            if (spin_results_due.size() == 0) begin
                $display("%0t: unexpected result beat, tdata %h", $time, m_data);
                fail_count++;
            end else begin
                want = spin_results_due.pop_front();
                compare_field("flipped", int'(want.flipped),
                              int'(m_data[ising_pkg::OUT_FLIP_LSB]));
                compare_field("spin_now", int'(want.spin_now),
                              int'(m_data[ising_pkg::OUT_SPIN_LSB]));
                compare_field("energy_sign", int'(want.energy_sign),
                              int'($signed(m_data[ising_pkg::OUT_SIGN_LSB +: ising_pkg::SIGN_W])));
                compare_field("magnetisation", int'(want.magnetisation),
                              int'($signed(m_data[ising_pkg::OUT_MAG_LSB +: ising_pkg::MAG_W])));
            end
        end
    end

    // watchdog on cycles with no beat on either side
    always @(posedge clk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog, no beat for %0d cycles", $time, quiet_cycles);
            $display("ising_metropolis_spin_update test failed");
            $finish;
        end
    end

    // reset, test sequence, final verdict
    initial begin
        reset_lattice();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        test_directed_sites();
        test_threshold_sweep();
        test_input_backpressure();
        test_random_mix();
        drain_results();
        repeat (8) @(posedge clk);
        if (fail_count == 0 && spin_results_due.size() == 0) begin
            $display("ising_metropolis_spin_update test passed");
        end else begin
            $display("ising_metropolis_spin_update test failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

FILE: files.f
+incdir+rtl/core
rtl/core/ising_pkg.sv
rtl/core/ising_metropolis_spin_update.sv
rtl/core/ising_chk.sv
test/testbench.sv
